// ----- src/mm3_pkg.sv -----
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared types, constants and helpers for the streaming 128-bit murmur3 hash.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned BLK_BYTES = 16;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned MUL_CNT_W = 3;

  localparam logic [APB_AW-1:0] ADDR_SEED = 3'd0;

  localparam logic [WORD_W-1:0] SEED_RESET = 64'h725acc55daddca55;
  localparam logic [WORD_W-1:0] MIX_C1     = 64'h87c37b91114253d5;
  localparam logic [WORD_W-1:0] MIX_C2     = 64'h4cf5ad432745937f;
  localparam logic [WORD_W-1:0] ADD_H1     = 64'h0000000052dce729;
  localparam logic [WORD_W-1:0] ADD_H2     = 64'h0000000038495ab5;
  localparam logic [WORD_W-1:0] FIN_M1     = 64'hff51afd7ed558ccd;
  localparam logic [WORD_W-1:0] FIN_M2     = 64'hc4ceb9fe1a85ec53;

  // last step of the shared multiplier sequence
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = 3'd4;

  typedef enum logic [1:0] {
    REQ_ABSORB  = 2'd0,
    REQ_FINISH  = 2'd1,
    REQ_RESTART = 2'd2
  } mm3_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A1,
    S_A2,
    S_B1,
    S_B2,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_MIX4,
    S_FIN1,
    S_FIN2,
    S_FIN3,
    S_FX0,
    S_FX1,
    S_FX2,
    S_FX3,
    S_FX4,
    S_ADD1,
    S_ADD2,
    S_OUT1,
    S_OUT2
  } mm3_state_t;

  typedef struct packed {
    logic              mix;
    logic              fin;
    logic              restart;
    logic [WORD_W-1:0] lane_lo;
    logic [WORD_W-1:0] lane_hi;
  } mm3_cmd_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                              input int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  function automatic logic [WORD_W-1:0] xsh33(input logic [WORD_W-1:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

// ----- src/mm3_req_if.sv -----
// ----------------------------------------------------------------------------
// mm3_req_if
// Request channel: one message byte, finish or restart per item.
// ----------------------------------------------------------------------------
interface mm3_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// ----- src/mm3_res_if.sv -----
// ----------------------------------------------------------------------------
// mm3_res_if
// Result channel: one 64-bit digest half per item.
// ----------------------------------------------------------------------------
interface mm3_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_word;
  logic        last_word;

  modport source (output valid, output hash_word, output last_word, input ready);
  modport sink   (input valid, input hash_word, input last_word, output ready);
endinterface

// ----- src/mm3_mul.sv -----
// ----------------------------------------------------------------------------
// mm3_mul
// Shared 64x64 multiplier, low half only, built from one 32x32 multiplier
// stepped over three partial products.
// ----------------------------------------------------------------------------
module mm3_mul
  import mm3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [WORD_W-1:0] result
);

  logic [MUL_CNT_W-1:0] cnt;
  logic [HALF_W-1:0]    op_x;
  logic [HALF_W-1:0]    op_y;
  logic [WORD_W-1:0]    prod;
  logic [WORD_W-1:0]    acc;

  // lo*lo, then the two cross terms; hi*hi falls outside the low 64 bits
  always_comb begin
    case (cnt)
      3'd0: begin
        op_x = a[HALF_W-1:0];
        op_y = b[HALF_W-1:0];
      end
      3'd1: begin
        op_x = a[HALF_W-1:0];
        op_y = b[WORD_W-1:HALF_W];
      end
      default: begin
        op_x = a[WORD_W-1:HALF_W];
        op_y = b[HALF_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || !go || cnt == MUL_LAST) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= WORD_W'(op_x) * WORD_W'(op_y);
    case (cnt)
      3'd1:         acc <= prod;
      3'd2, 3'd3:   acc <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      default:      acc <= acc;
    endcase
  end

  assign done   = go && (cnt == MUL_LAST);
  assign result = acc;

endmodule

// ----- src/mm3_engine.sv -----
// ----------------------------------------------------------------------------
// mm3_engine
// Sequencer around the shared multiplier: block mixing, tail mixing,
// finalisation and the two digest results.
// ----------------------------------------------------------------------------
module mm3_engine
  import mm3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mm3_cmd_t          cmd,
  input  logic [WORD_W-1:0] seed,
  input  logic [WORD_W-1:0] total_len,
  output logic              idle,
  mm3_res_if.source         res
);

  mm3_state_t st, st_next;

  logic [WORD_W-1:0] h1, h2;
  logic [WORD_W-1:0] ka, kb;
  logic [WORD_W-1:0] x, y;
  logic              is_fin;
  logic              on_y;

  logic              mul_go;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic              mul_done;
  logic [WORD_W-1:0] mul_res;
  logic [WORD_W-1:0] sel_w;

  assign sel_w = on_y ? y : x;

  mm3_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .go     (mul_go),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:  if (cmd.mix || cmd.fin) st_next = S_A1;
      S_A1:    if (mul_done) st_next = S_A2;
      S_A2:    if (mul_done) st_next = S_B1;
      S_B1:    if (mul_done) st_next = S_B2;
      S_B2:    if (mul_done) st_next = is_fin ? S_FIN1 : S_MIX1;
      S_MIX1:  st_next = S_MIX2;
      S_MIX2:  st_next = S_MIX3;
      S_MIX3:  st_next = S_MIX4;
      S_MIX4:  st_next = S_IDLE;
      S_FIN1:  st_next = S_FIN2;
      S_FIN2:  st_next = S_FIN3;
      S_FIN3:  st_next = S_FX0;
      S_FX0:   st_next = S_FX1;
      S_FX1:   if (mul_done) st_next = S_FX2;
      S_FX2:   st_next = S_FX3;
      S_FX3:   if (mul_done) st_next = S_FX4;
      S_FX4:   st_next = on_y ? S_ADD1 : S_FX0;
      S_ADD1:  st_next = S_ADD2;
      S_ADD2:  st_next = S_OUT1;
      S_OUT1:  if (res.ready) st_next = S_OUT2;
      S_OUT2:  if (res.ready) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_go        = 1'b0;
    mul_a         = ka;
    mul_b         = MIX_C1;
    res.valid     = 1'b0;
    res.last_word = 1'b0;
    res.hash_word = x;
    unique case (st)
      S_A1: begin
        mul_go = 1'b1;
        mul_a  = ka;
        mul_b  = MIX_C1;
      end
      S_A2: begin
        mul_go = 1'b1;
        mul_a  = ka;
        mul_b  = MIX_C2;
      end
      S_B1: begin
        mul_go = 1'b1;
        mul_a  = kb;
        mul_b  = MIX_C2;
      end
      S_B2: begin
        mul_go = 1'b1;
        mul_a  = kb;
        mul_b  = MIX_C1;
      end
      S_FX1: begin
        mul_go = 1'b1;
        mul_a  = sel_w;
        mul_b  = FIN_M1;
      end
      S_FX3: begin
        mul_go = 1'b1;
        mul_a  = sel_w;
        mul_b  = FIN_M2;
      end
      S_OUT1: begin
        res.valid     = 1'b1;
        res.hash_word = x;
      end
      S_OUT2: begin
        res.valid     = 1'b1;
        res.last_word = 1'b1;
        res.hash_word = y;
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1     <= SEED_RESET;
      h2     <= SEED_RESET;
      is_fin <= 1'b0;
      on_y   <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          if (cmd.restart) begin
            h1 <= seed;
            h2 <= seed;
          end
          if (cmd.mix || cmd.fin) begin
            is_fin <= cmd.fin;
          end
        end
        S_MIX2:  h1 <= (x << 2) + x + ADD_H1;
        S_MIX4:  h2 <= (x << 2) + x + ADD_H2;
        S_FIN3:  on_y <= 1'b0;
        S_FX4:   on_y <= 1'b1;
        default: on_y <= on_y;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        ka <= cmd.lane_lo;
        kb <= cmd.lane_hi;
      end
      S_A1:   if (mul_done) ka <= rotl(mul_res, 31);
      S_A2:   if (mul_done) ka <= mul_res;
      S_B1:   if (mul_done) kb <= rotl(mul_res, 33);
      S_B2:   if (mul_done) kb <= mul_res;
      S_MIX1: x <= rotl(h1 ^ ka, 27) + h2;
      S_MIX3: x <= rotl(h2 ^ kb, 31) + h1;
      S_FIN1: begin
        x <= h1 ^ ka ^ total_len;
        y <= h2 ^ kb ^ total_len;
      end
      S_FIN2: x <= x + y;
      S_FIN3: y <= y + x;
      S_FX0, S_FX2, S_FX4: begin
        if (on_y) y <= xsh33(y);
        else      x <= xsh33(x);
      end
      S_FX1, S_FX3: begin
        if (mul_done) begin
          if (on_y) y <= mul_res;
          else      x <= mul_res;
        end
      end
      S_ADD1: x <= x + y;
      S_ADD2: y <= y + x;
      default: begin
        ka <= ka;
      end
    endcase
  end

  assign idle = (st == S_IDLE);

  a_cmd_when_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.mix || cmd.fin || cmd.restart) |-> st == S_IDLE)
    else $error("engine command issued while busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.mix, cmd.fin, cmd.restart}) <= 1)
    else $error("engine commands overlap");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && res.last_word) |=> st == S_IDLE)
    else $error("engine not idle after last digest word");

endmodule

// ----- src/murmur3_x64_128_hash.sv -----
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash
// Streaming 128-bit murmur3 (x64): bytes gathered into 16-byte blocks, each
// block mixed by a sequenced shared multiplier, digest emitted on finish.
// ----------------------------------------------------------------------------
// block: bytes are taken while the engine is idle; the 16th byte of a block starts four
//   64-bit multiplies on the shared unit and the mix steps, and no request is taken meanwhile
// finish: tail mixing and finalisation run before the first result, then h1 and h2 as two items
// restart and unused request codes do not start the engine
// reset: seed, both hash halves to the seed reset value; position, length 0
// ----------------------------------------------------------------------------
module murmur3_x64_128_hash
  import mm3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  mm3_req_if.sink               req,
  mm3_res_if.source             res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [WORD_W-1:0]     pwdata,
  output logic [WORD_W-1:0]     prdata,
  output logic                  pready
);

  logic [WORD_W-1:0] seed;
  logic [7:0]        blk [BLK_BYTES];
  logic [POS_W-1:0]  pos;
  logic [WORD_W-1:0] len;
  logic              mix_pend;
  logic              eng_idle;
  logic              acc_in;
  mm3_req_t          rtype;
  mm3_cmd_t          cmd;
  logic [WORD_W-1:0] full_lo, full_hi;
  logic [WORD_W-1:0] tail_lo, tail_hi;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SEED) ? seed : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_SEED) begin
      seed <= pwdata;
    end
  end

  assign req.ready = eng_idle && !mix_pend;
  assign acc_in    = req.valid && req.ready;
  assign rtype     = mm3_req_t'(req.req_type);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      len      <= '0;
      mix_pend <= 1'b0;
    end else begin
      mix_pend <= 1'b0;
      if (acc_in) begin
        unique case (rtype)
          REQ_ABSORB: begin
            pos      <= pos + 1'b1;
            len      <= len + 1'b1;
            mix_pend <= (pos == POS_W'(BLK_BYTES - 1));
          end
          REQ_RESTART: begin
            pos <= '0;
            len <= '0;
          end
          default: begin
            pos <= pos;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && rtype == REQ_ABSORB) begin
      blk[pos] <= req.data_byte;
    end
  end

  // little-endian lanes, tail bytes at and above the position read as zero
  always_comb begin
    for (int i = 0; i < BLK_BYTES / 2; i++) begin
      full_lo[8*i +: 8] = blk[i];
      full_hi[8*i +: 8] = blk[i + BLK_BYTES / 2];
      tail_lo[8*i +: 8] = (POS_W'(i) < pos) ? blk[i] : 8'h00;
      tail_hi[8*i +: 8] = (POS_W'(i + BLK_BYTES / 2) < pos) ?
                          blk[i + BLK_BYTES / 2] : 8'h00;
    end
  end

  always_comb begin
    cmd.mix     = mix_pend;
    cmd.fin     = acc_in && rtype == REQ_FINISH;
    cmd.restart = acc_in && rtype == REQ_RESTART;
    cmd.lane_lo = mix_pend ? full_lo : tail_lo;
    cmd.lane_hi = mix_pend ? full_hi : tail_hi;
  end

  mm3_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .seed      (seed),
    .total_len (len),
    .idle      (eng_idle),
    .res       (res)
  );

  a_pend_one_cycle: assert property (@(posedge clk) disable iff (rst)
    mix_pend |=> !mix_pend)
    else $error("block mix request held too long");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (acc_in && rtype == REQ_ABSORB && pos == POS_W'(BLK_BYTES - 1)) |=>
      (mix_pend && pos == '0))
    else $error("full block not handed to the engine");

  a_busy_after_mix: assert property (@(posedge clk) disable iff (rst)
    mix_pend |=> !eng_idle && !req.ready)
    else $error("engine did not start on a full block");

endmodule
